@@ src/lsa_pkg.sv @@
// Package with the types and constants shared by the slot allocator cell chain and its top level.
package lsa_pkg;

	localparam int NUM_SLOTS = 16;
	localparam int OWNER_W   = 22;
	localparam int IDX_W     = 8;
	localparam int SLOT_W    = 4;
	localparam int CNT_W     = 5;

	localparam logic [1:0] ST_GRANT   = 2'd0;
	localparam logic [1:0] ST_RELEASE = 2'd1;
	localparam logic [1:0] ST_FAIL    = 2'd2;

	localparam logic REQ_ACQUIRE = 1'b0;
	localparam logic REQ_RELEASE = 1'b1;

	// Request token that walks down the chain of slot cells.
	typedef struct packed {
		logic               live;      // owner id is nonzero
		logic               kind;      // REQ_ACQUIRE or REQ_RELEASE
		logic [OWNER_W-1:0] owner;
		logic [IDX_W-1:0]   slot_index;
		logic               hit;       // some cell has granted or released
		logic [IDX_W-1:0]   slot;      // granted slot
	} req_tok_t;

endpackage

@@ src/license_slot_allocator_core.sv @@
// Top level of the license slot allocator: request register, chain of slot cells, reply register.
// Usage:
// A request is taken at a rising edge where start is high and busy is low. req_type selects
// acquire (lowest free slot is given to owner_id) or release (slot_index is freed if it holds
// owner_id). Owner id zero, a full table, an out-of-range slot or a foreign owner all fail.
// The request is registered, then walks the chain of NUM_SLOTS slot cells, one cell per
// cycle; each cell owns one slot and acts on the request as it passes. Every request gives
// exactly one reply, shown for one cycle with done high: status, reply_slot, reply_owner and
// slots_in_use (count after the request).
// Busy stays high until the reply is shown, so a new request is taken only once the previous
// one has walked the whole cell chain and given its reply.
// The reply cannot be held off: it must be taken in the cycle that done is high.
// An asynchronous reset (arst_n low) frees every slot and clears the count and busy.
module license_slot_allocator_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         req_type,
	input  logic [lsa_pkg::OWNER_W-1:0]  owner_id,
	input  logic [lsa_pkg::IDX_W-1:0]    slot_index,
	output logic                         done,
	output logic [1:0]                   status,
	output logic [lsa_pkg::SLOT_W-1:0]   reply_slot,
	output logic [lsa_pkg::OWNER_W-1:0]  reply_owner,
	output logic [lsa_pkg::CNT_W-1:0]    slots_in_use
);
	import lsa_pkg::*;

	logic                busy_q;
	logic                in_vld_q;
	req_tok_t            in_tok_q;
	logic                done_q;
	logic [1:0]          status_q;
	logic [SLOT_W-1:0]   reply_slot_q;
	logic [OWNER_W-1:0]  reply_owner_q;
	logic [CNT_W-1:0]    count_q;

	logic                tok_vld [0:NUM_SLOTS];
	req_tok_t            tok     [0:NUM_SLOTS];
	logic [NUM_SLOTS-1:0] occ;

	logic                accept;
	logic                exit_vld;
	req_tok_t            exit_tok;
	logic [CNT_W-1:0]    count_next;
	logic [1:0]          status_next;

	assign accept = start && !busy_q;

	assign tok_vld[0] = in_vld_q;
	assign tok[0]     = in_tok_q;

	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
		lsa_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cell_idx    (IDX_W'(i)),
			.tok_vld_in  (tok_vld[i]),
			.tok_in      (tok[i]),
			.tok_vld_out (tok_vld[i+1]),
			.tok_out     (tok[i+1]),
			.occupied    (occ[i])
		);
	end

	assign exit_vld = tok_vld[NUM_SLOTS];
	assign exit_tok = tok[NUM_SLOTS];

	always_comb begin
		count_next  = count_q;
		status_next = ST_FAIL;
		if (exit_tok.hit) begin
			if (exit_tok.kind == REQ_ACQUIRE) begin
				status_next = ST_GRANT;
				count_next  = count_q + CNT_W'(1);
			end else begin
				status_next = ST_RELEASE;
				if (count_q != '0) begin
					count_next = count_q - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			in_vld_q <= 1'b0;
			done_q   <= 1'b0;
			count_q  <= '0;
		end else begin
			in_vld_q <= accept;
			done_q   <= exit_vld;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (exit_vld) begin
				busy_q <= 1'b0;
			end
			if (exit_vld) begin
				count_q <= count_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_tok_q.live       <= (owner_id != '0);
			in_tok_q.kind       <= req_type;
			in_tok_q.owner      <= owner_id;
			in_tok_q.slot_index <= slot_index;
			in_tok_q.hit        <= 1'b0;
			in_tok_q.slot       <= '0;
		end
		if (exit_vld) begin
			status_q      <= status_next;
			reply_slot_q  <= (status_next == ST_GRANT) ? exit_tok.slot[SLOT_W-1:0] : '0;
			reply_owner_q <= exit_tok.owner;
		end
	end

	assign busy         = busy_q;
	assign done         = done_q;
	assign status       = status_q;
	assign reply_slot   = reply_slot_q;
	assign reply_owner  = reply_owner_q;
	assign slots_in_use = count_q;

	// The reply appears in the same cycle that busy drops.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("reply shown while a request is still in flight");

	// An accepted request comes back as a reply, with done high, after the full chain walk.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy_q) |-> ##(NUM_SLOTS + 2) done_q)
		else $error("reply did not arrive after the chain walk");

	// When idle, the count agrees with the number of occupied cells.
	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (count_q == CNT_W'($countones(occ))))
		else $error("slot count disagrees with occupied cells");

	// A grant never comes with a table that was already full.
	a_grant_room: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == ST_GRANT) |-> (count_q != '0 && count_q <= CNT_W'(NUM_SLOTS)))
		else $error("grant reported with an impossible slot count");

endmodule

@@ src/lsa_cell.sv @@
// One slot cell: holds a single slot owner and passes the request token to the next cell.
module lsa_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [lsa_pkg::IDX_W-1:0]  cell_idx,
	input  logic                       tok_vld_in,
	input  lsa_pkg::req_tok_t          tok_in,
	output logic                       tok_vld_out,
	output lsa_pkg::req_tok_t          tok_out,
	output logic                       occupied
);
	import lsa_pkg::*;

	logic [OWNER_W-1:0] owner_q;
	logic               vld_q;
	req_tok_t           tok_q;
	logic               active;
	logic               acq_hit;
	logic               rel_hit;
	req_tok_t           tok_next;

	assign active  = tok_vld_in && tok_in.live && !tok_in.hit;
	assign acq_hit = active && (tok_in.kind == REQ_ACQUIRE) && (owner_q == '0);
	assign rel_hit = active && (tok_in.kind == REQ_RELEASE)
		&& (tok_in.slot_index == cell_idx) && (owner_q == tok_in.owner);

	always_comb begin
		tok_next = tok_in;
		if (acq_hit || rel_hit) begin
			tok_next.hit = 1'b1;
		end
		if (acq_hit) begin
			tok_next.slot = cell_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owner_q <= '0;
			vld_q   <= 1'b0;
		end else begin
			vld_q <= tok_vld_in;
			if (acq_hit) begin
				owner_q <= tok_in.owner;
			end else if (rel_hit) begin
				owner_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_next;
	end

	assign tok_vld_out = vld_q;
	assign tok_out     = tok_q;
	assign occupied    = (owner_q != '0);

endmodule
